FILE: rtl/dda_pkg.sv
// Shared widths, codes and types for the DDA line rasterizer.
`default_nettype none

package dda_pkg;

    localparam int COORD_W = 20;   // signed Q12.8 input coordinate
    localparam int FRAC_IN = 8;    // fraction bits of an input coordinate
    localparam int MAG_W   = 20;   // magnitude of a coordinate delta
    localparam int POS_W   = 29;   // signed Q13.16 position
    localparam int FRAC_W  = 16;   // fraction bits of position and increment
    localparam int STEP_W  = 18;   // signed Q1.16 increment
    localparam int QUOT_W  = 17;   // unsigned increment magnitude, at most 1.0
    localparam int PIX_W   = 13;   // signed pixel coordinate
    localparam int COLOR_W = 32;
    localparam int CFG_W   = 6;    // width of a half-size register

    localparam int S_DATA_W = 112; // four coordinates and the color, padded to bytes
    localparam int M_DATA_W = 64;  // two pixel coordinates and the color, padded

    typedef enum logic [0:0] {
        CFG_HALF_WIDTH  = 1'b0,
        CFG_HALF_HEIGHT = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DELTA,
        ST_RANGE,
        ST_DIV_X,
        ST_DIV_Y,
        ST_EMIT
    } dda_state_t;

    // Request to the shared divider: quotient = floor(num * 2^16 / den), num <= den.
    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] num;
        logic [MAG_W-1:0] den;
    } dda_div_req_t;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } dda_div_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/dda_line_rasterizer.sv
// Top level of the DDA line rasterizer: sequencer, position stepper and output register.
// Flow: the input beat is followed by the delta and range steps, two divider passes
//   (x, then y) and the output load. The block takes no new segment until the last pixel
//   is loaded; pixels leave at one per cycle while the consumer does not stall.
// Reset: aresetn is synchronous and active low; it empties the sequencer and the
//   output register and sets both half-size registers to 32.
`default_nettype none

module dda_line_rasterizer
    import dda_pkg::*;
#(
    parameter int MAX_HALF = 32
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,

    // Configuration write port.
    input  wire logic                cfg_wr_en,
    input  wire logic [0:0]          cfg_addr,
    input  wire logic [CFG_W-1:0]    cfg_wdata,

    // Segment input. tdata from bit 0 up: start_x[19:0], start_y[39:20],
    // end_x[59:40], end_y[79:60], color[111:80].
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,

    // Pixel output. tdata from bit 0 up: pixel_x[12:0], pixel_y[25:13],
    // pixel_color[57:26], zero padding[63:58]. tlast marks the segment's last pixel.
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata,
    output logic                     m_tlast
);

    // Width of an effective half size and of the step counter.
    localparam int HW = $clog2(MAX_HALF + 1);
    localparam logic [CFG_W-1:0] MAX_HALF_C = CFG_W'(MAX_HALF);

    // Clamp a register value to the range 1 .. MAX_HALF.
    function automatic logic [HW-1:0] eff_half(input logic [CFG_W-1:0] h);
        if (h == '0) begin
            return HW'(1);
        end else if (h > MAX_HALF_C) begin
            return HW'(MAX_HALF);
        end else begin
            return h[HW-1:0];
        end
    endfunction

    // Truncate a Q13.16 position toward zero: a negative value with a nonzero
    // fraction rounds up by one from the arithmetic shift.
    function automatic logic [PIX_W-1:0] trunc_pixel(input logic [POS_W-1:0] p);
        logic bump;
        bump = p[POS_W-1] && (p[FRAC_W-1:0] != '0);
        return p[POS_W-1:FRAC_W] + {{(PIX_W-1){1'b0}}, bump};
    endfunction

    // Configuration registers.
    logic [CFG_W-1:0]   half_width_reg;
    logic [CFG_W-1:0]   half_height_reg;

    // Sequencer and segment state.
    dda_state_t         state_reg, state_next;
    logic [COORD_W-1:0] sx_reg, sy_reg, ex_reg, ey_reg;
    logic [COLOR_W-1:0] held_color_reg;
    logic [MAG_W-1:0]   ax_reg, ay_reg, dmax_reg;
    logic               neg_x_reg, neg_y_reg;
    logic [POS_W-1:0]   pos_x_reg, pos_y_reg;
    logic [STEP_W-1:0]  step_x_reg, step_y_reg;
    logic [HW-1:0]      steps_left_reg;

    // Output register.
    logic               m_valid_reg;
    logic [PIX_W-1:0]   out_x_reg, out_y_reg;
    logic [COLOR_W-1:0] out_color_reg;
    logic               out_last_reg;

    dda_div_req_t       div_req;
    dda_div_rsp_t       div_rsp;

    logic               in_beat;
    logic               load_pixel;
    logic [MAG_W:0]     dx_w, dy_w;
    logic [MAG_W:0]     ax_w, ay_w;
    logic               x_major;
    logic [MAG_W-1:0]   dmax_w;
    logic [MAG_W-1:0]   a_sel;
    logic [HW-1:0]      h_sel;
    logic [MAG_W-1:0]   h_q8;
    logic [HW-1:0]      steps_init;
    logic [STEP_W-1:0]  quot_signed_x, quot_signed_y;

    assign in_beat    = s_tvalid && s_tready;
    assign s_tready   = (state_reg == ST_IDLE);
    // While the sequencer emits, a pixel moves into the output register whenever
    // that register is free or is being emptied in this cycle.
    assign load_pixel = (state_reg == ST_EMIT) && (!m_valid_reg || m_tready);

    // Deltas in 21-bit two's complement; their magnitudes always fit 20 bits.
    always_comb begin
        dx_w = {ex_reg[COORD_W-1], ex_reg} - {sx_reg[COORD_W-1], sx_reg};
        dy_w = {ey_reg[COORD_W-1], ey_reg} - {sy_reg[COORD_W-1], sy_reg};
        ax_w = dx_w[MAG_W] ? (~dx_w + 1'b1) : dx_w;
        ay_w = dy_w[MAG_W] ? (~dy_w + 1'b1) : dy_w;
    end

    // Axis choice: x rule only when |dx| is strictly larger, so ties go to y.
    always_comb begin
        x_major    = ax_reg > ay_reg;
        dmax_w     = x_major ? ax_reg : ay_reg;
        a_sel      = dmax_w;
        h_sel      = x_major ? eff_half(half_width_reg) : eff_half(half_height_reg);
        h_q8       = {{(MAG_W-HW-FRAC_IN){1'b0}}, h_sel, {FRAC_IN{1'b0}}};
        steps_init = (a_sel > h_q8) ? (h_sel - HW'(1)) : a_sel[HW+FRAC_IN-1:FRAC_IN];
    end

    // Signed increments from the divider's magnitude; a zero-length segment
    // gets no movement at all.
    always_comb begin
        quot_signed_x = neg_x_reg ? (~{1'b0, div_rsp.quot} + 1'b1) : {1'b0, div_rsp.quot};
        quot_signed_y = neg_y_reg ? (~{1'b0, div_rsp.quot} + 1'b1) : {1'b0, div_rsp.quot};
        if (dmax_reg == '0) begin
            quot_signed_x = '0;
            quot_signed_y = '0;
        end
    end

    // Divider requests: x starts as the range is settled, y as x finishes.
    always_comb begin
        div_req.start = 1'b0;
        div_req.num   = ax_reg;
        div_req.den   = dmax_w;
        if (state_reg == ST_RANGE) begin
            div_req.start = 1'b1;
        end else if ((state_reg == ST_DIV_X) && div_rsp.done) begin
            div_req.start = 1'b1;
            div_req.num   = ay_reg;
            div_req.den   = dmax_reg;
        end
    end

    dda_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Sequencer next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    state_next = ST_DELTA;
                end
            end
            ST_DELTA: begin
                state_next = ST_RANGE;
            end
            ST_RANGE: begin
                state_next = ST_DIV_X;
            end
            ST_DIV_X: begin
                if (div_rsp.done) begin
                    state_next = ST_DIV_Y;
                end
            end
            ST_DIV_Y: begin
                if (div_rsp.done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (load_pixel && (steps_left_reg == '0)) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_width_reg  <= CFG_W'(32);
            half_height_reg <= CFG_W'(32);
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_addr))
                CFG_HALF_WIDTH:  half_width_reg  <= cfg_wdata;
                CFG_HALF_HEIGHT: half_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Segment datapath. The position starts at the start point scaled to Q13.16
    // and moves by one increment after each pixel that is not the last.
    always_ff @(posedge aclk) begin
        if (in_beat) begin
            sx_reg         <= s_tdata[COORD_W-1:0];
            sy_reg         <= s_tdata[2*COORD_W-1:COORD_W];
            ex_reg         <= s_tdata[3*COORD_W-1:2*COORD_W];
            ey_reg         <= s_tdata[4*COORD_W-1:3*COORD_W];
            held_color_reg <= s_tdata[4*COORD_W+COLOR_W-1:4*COORD_W];
        end
        if (state_reg == ST_DELTA) begin
            ax_reg    <= ax_w[MAG_W-1:0];
            ay_reg    <= ay_w[MAG_W-1:0];
            neg_x_reg <= dx_w[MAG_W];
            neg_y_reg <= dy_w[MAG_W];
            pos_x_reg <= {sx_reg[COORD_W-1], sx_reg, {FRAC_IN{1'b0}}};
            pos_y_reg <= {sy_reg[COORD_W-1], sy_reg, {FRAC_IN{1'b0}}};
        end
        if (state_reg == ST_RANGE) begin
            dmax_reg       <= dmax_w;
            steps_left_reg <= steps_init;
        end
        if ((state_reg == ST_DIV_X) && div_rsp.done) begin
            step_x_reg <= quot_signed_x;
        end
        if ((state_reg == ST_DIV_Y) && div_rsp.done) begin
            step_y_reg <= quot_signed_y;
        end
        if (load_pixel && (steps_left_reg != '0)) begin
            steps_left_reg <= steps_left_reg - HW'(1);
            pos_x_reg <= pos_x_reg + {{(POS_W-STEP_W){step_x_reg[STEP_W-1]}}, step_x_reg};
            pos_y_reg <= pos_y_reg + {{(POS_W-STEP_W){step_y_reg[STEP_W-1]}}, step_y_reg};
        end
    end

    // Output register: holds a pixel beat until the consumer takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_pixel) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_pixel) begin
            out_x_reg     <= trunc_pixel(pos_x_reg);
            out_y_reg     <= trunc_pixel(pos_y_reg);
            out_color_reg <= held_color_reg;
            out_last_reg  <= (steps_left_reg == '0);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(M_DATA_W-2*PIX_W-COLOR_W){1'b0}}, out_color_reg, out_y_reg, out_x_reg};

    // The divider reports a finished quotient only while the sequencer waits for it.
    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> ((state_reg == ST_DIV_X) || (state_reg == ST_DIV_Y)))
        else $error("divider finished outside a divide state");

    // A new pixel beat appears only as the sequencer emits.
    a_valid_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_EMIT))
        else $error("pixel beat raised outside the emit state");

    // Loading the final pixel returns the sequencer to idle with tlast set.
    a_last_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_pixel && (steps_left_reg == '0)) |=> ((state_reg == ST_IDLE) && out_last_reg))
        else $error("final pixel did not close the segment");

    // An accepted segment always starts with the delta cycle.
    a_accept_to_delta: assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat |=> (state_reg == ST_DELTA))
        else $error("accepted segment did not enter the delta state");

endmodule

`default_nettype wire

FILE: rtl/dda_div.sv
// Restoring fractional divider, one quotient bit per cycle, shared by both axes.
`default_nettype none

module dda_div
    import dda_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire dda_div_req_t req,
    output dda_div_rsp_t      rsp
);

    localparam int CNT_W = $clog2(QUOT_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUOT_W - 1);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [MAG_W:0]      rem_reg;
    logic [MAG_W-1:0]    den_reg;
    logic [QUOT_W-1:0]   quot_reg;

    logic [MAG_W:0]      trial;
    logic                fits;
    logic [MAG_W:0]      rem_next;

    // The first step decides the integer bit (num >= den); every later step
    // doubles the remainder before the compare.
    always_comb begin
        trial    = (cnt_reg == '0) ? rem_reg : {rem_reg[MAG_W-1:0], 1'b0};
        fits     = trial >= {1'b0, den_reg};
        rem_next = fits ? (trial - {1'b0, den_reg}) : trial;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg  <= {1'b0, req.num};
            den_reg  <= req.den;
            quot_reg <= '0;
        end else if (busy_reg) begin
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[QUOT_W-2:0], fits};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

`default_nettype wire

FILE: verif/dda_line_rasterizer_test.sv
// Self-checking testbench for the DDA line rasterizer: random segments, pixel-by-pixel check.
`default_nettype none

module dda_line_rasterizer_test
    import dda_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // The half-size limit the block is built with. The predictor clamps the
    // registers to the same value.
    localparam int HALF_LIMIT = 32;

    // Cycles without any beat before the run is declared hung. The slowest
    // correct stretch is a sender gap, the block's setup for one segment and
    // one receiver stall.
    localparam int HANG_LIMIT = 4000;

    // Cycles allowed after the last expected pixel for stray beats to show up.
    localparam int TAIL_CYCLES = 60;

    // One segment waiting to be sent. When hold_until_empty is set, the sender
    // does not offer it before every pixel predicted so far has come back.
    typedef struct {
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [COORD_W-1:0] ex;
        logic signed [COORD_W-1:0] ey;
        logic [COLOR_W-1:0]        color;
        bit                        hold_until_empty;
    } segment_t;

    // One predicted pixel beat.
    typedef struct {
        logic signed [PIX_W-1:0] x;
        logic signed [PIX_W-1:0] y;
        logic [COLOR_W-1:0]      color;
        logic                    last;
    } pixel_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [0:0]          cfg_addr = CFG_HALF_WIDTH;
    logic [CFG_W-1:0]    cfg_wdata = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;

    // Segments still to be sent, and pixels predicted but not yet seen.
    segment_t segments_pending[$];
    pixel_t   pixels_due[$];

    // The predictor's copy of the two half-size registers, as written.
    logic [CFG_W-1:0] model_half_width = 6'd32;
    logic [CFG_W-1:0] model_half_height = 6'd32;

    int  mismatches = 0;
    int  quiet_cycles = 0;
    bit  out_drained = 1'b1;

    // Sender burst and gap bookkeeping, receiver stall bookkeeping.
    int  burst_left = 0;
    int  gap_left = 0;
    int  ready_left = 0;

    dda_line_rasterizer #(
        .MAX_HALF (HALF_LIMIT)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // start_x, start_y, end_x, end_y, color from bit 0 up
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // pixel_x, pixel_y, pixel_color, zero padding from bit 0 up
        .m_tlast   (m_tlast)
    );

    always #4 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // A Q13.16 position truncated toward zero, kept to the pixel width.
    function automatic logic signed [PIX_W-1:0] trunc_to_pixel(longint pos);
        longint whole;
        whole = (pos >= 0) ? (pos >>> FRAC_W) : -((-pos) >>> FRAC_W);
        return whole[PIX_W-1:0];
    endfunction

    // A half-size register as the block uses it: zero counts as one, and
    // anything above the build limit counts as the limit.
    function automatic longint usable_half(logic [CFG_W-1:0] raw);
        if (raw == 0) return 1;
        if (raw > HALF_LIMIT) return HALF_LIMIT;
        return longint'(raw);
    endfunction

    // Works out every pixel of one segment beat and queues them in order.
    function automatic void predict_segment(logic [S_DATA_W-1:0] beat);
        longint sx, sy, ex, ey, dx, dy, ax, ay, dmax;
        longint inc_x, inc_y, px, py, half, major;
        int     steps;
        pixel_t pix;
        sx = longint'($signed(beat[19:0]));
        sy = longint'($signed(beat[39:20]));
        ex = longint'($signed(beat[59:40]));
        ey = longint'($signed(beat[79:60]));
        dx = ex - sx;
        dy = ey - sy;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        dmax = (ax > ay) ? ax : ay;

        // Per-step increments in Q1.16; a zero-length segment does not move.
        inc_x = 0;
        inc_y = 0;
        if (dmax != 0) begin
            inc_x = (ax << FRAC_W) / dmax;
            inc_y = (ay << FRAC_W) / dmax;
            if (dx < 0) inc_x = -inc_x;
            if (dy < 0) inc_y = -inc_y;
        end

        // The x rule only wins on a strictly larger x delta; ties go to y.
        if (ax > ay) begin
            half = usable_half(model_half_width);
            major = ax;
        end else begin
            half = usable_half(model_half_height);
            major = ay;
        end
        if (major > (half << FRAC_IN)) steps = int'(half - 1);
        else steps = int'(major >>> FRAC_IN);

        px = sx * 256;
        py = sy * 256;
        pix.color = beat[111:80];
        for (int k = 0; k <= steps; k++) begin
            pix.x = trunc_to_pixel(px);
            pix.y = trunc_to_pixel(py);
            pix.last = (k == steps);
            pixels_due.push_back(pix);
            px += inc_x;
            py += inc_y;
        end
    endfunction

    // ------------------------------------------------------------------
    // Sender: bursts of random length with random gaps in between. A
    // segment marked hold_until_empty waits until nothing is in flight.
    // ------------------------------------------------------------------

    // The drained flag is sampled at the falling edge so the sender reads a
    // settled value at the next rising edge.
    always @(negedge aclk) begin
        out_drained = (pixels_due.size() == 0);
    end

    always @(posedge aclk) begin
        segment_t seg;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left != 0) begin
                s_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (segments_pending.size() != 0 &&
                         (!segments_pending[0].hold_until_empty ||
                          (!s_tvalid && out_drained))) begin
                seg = segments_pending.pop_front();
                s_tdata <= {seg.color, seg.ey, seg.ex, seg.sy, seg.sx};
                s_tvalid <= 1'b1;
                if (burst_left <= 1) begin
                    // Start a new burst; a quarter of the time there is no gap at all.
                    burst_left <= ($urandom_range(0, 5) == 0) ? int'($urandom_range(20, 40))
                                                             : int'($urandom_range(1, 8));
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 12));
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: alternating ready and stall runs of random length, with an
    // occasional long stretch of steady ready.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (ready_left != 0) begin
            ready_left <= ready_left - 1;
        end else if (m_tready) begin
            m_tready <= 1'b0;
            ready_left <= $urandom_range(0, 5);
        end else begin
            m_tready <= 1'b1;
            ready_left <= ($urandom_range(0, 7) == 0) ? 150 : int'($urandom_range(0, 10));
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on every accepted segment beat and checks every
    // accepted pixel beat against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        pixel_t want;
        logic signed [PIX_W-1:0] got_x, got_y;
        logic [COLOR_W-1:0]      got_color;
        if (aresetn) begin
            if (s_tvalid && s_tready) predict_segment(s_tdata);
            if (m_tvalid && m_tready) begin
                got_x = m_tdata[12:0];
                got_y = m_tdata[25:13];
                got_color = m_tdata[57:26];
                if (pixels_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%t: pixel beat with none expected: x=%0d y=%0d color=%h last=%b",
                                 $realtime, got_x, got_y, got_color, m_tlast);
                end else begin
                    want = pixels_due.pop_front();
                    if (got_x !== want.x || got_y !== want.y ||
                        got_color !== want.color || m_tlast !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%t: pixel mismatch: expected x=%0d y=%0d color=%h last=%b",
                                     $realtime, want.x, want.y, want.color, want.last);
                            $display("%t:                      got x=%0d y=%0d color=%h last=%b",
                                     $realtime, got_x, got_y, got_color, m_tlast);
                        end
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: a long stretch with no beat on any port means a hang.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= HANG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    function automatic segment_t make_segment(int sx, int sy, int ex, int ey,
                                              logic [COLOR_W-1:0] color);
        segment_t seg;
        seg.sx = COORD_W'(sx);
        seg.sy = COORD_W'(sy);
        seg.ex = COORD_W'(ex);
        seg.ey = COORD_W'(ey);
        seg.color = color;
        seg.hold_until_empty = 1'b0;
        return seg;
    endfunction

    // A random segment. Most are short runs from anywhere in the coordinate
    // range; the rest are arbitrary endpoints, points, axis-aligned and
    // diagonal runs, and runs that start on the range's corners.
    function automatic segment_t random_segment();
        segment_t seg;
        int sx, sy, dx, dy, span;
        int kind;
        kind = $urandom_range(0, 9);
        span = ($urandom_range(0, 1) == 0) ? 12 * 256 : 40 * 256;
        sx = int'($urandom_range(0, 1040000)) - 520000;
        sy = int'($urandom_range(0, 1040000)) - 520000;
        dx = int'($urandom_range(0, 2 * span)) - span;
        dy = int'($urandom_range(0, 2 * span)) - span;
        case (kind)
            6: begin
                seg = make_segment(0, 0, 0, 0, $urandom());
                seg.sx = COORD_W'($urandom());
                seg.sy = COORD_W'($urandom());
                seg.ex = COORD_W'($urandom());
                seg.ey = COORD_W'($urandom());
                return seg;
            end
            7: begin
                dx = 0;
                dy = 0;
            end
            8: begin
                case ($urandom_range(0, 3))
                    0: dy = 0;
                    1: dx = 0;
                    2: dy = dx;
                    default: dy = -dx;
                endcase
            end
            9: begin
                // Start on a corner and step inward.
                sx = ($urandom_range(0, 1) == 0) ? -524288 : 524287;
                sy = ($urandom_range(0, 1) == 0) ? -524288 : 524287;
                dx = (sx < 0) ? (dx < 0 ? -dx : dx) : (dx < 0 ? dx : -dx);
                dy = (sy < 0) ? (dy < 0 ? -dy : dy) : (dy < 0 ? dy : -dy);
            end
            default: ;
        endcase
        return make_segment(sx, sy, sx + dx, sy + dy, $urandom());
    endfunction

    // Writes one half-size register and updates the predictor's copy.
    task automatic write_half(cfg_index_t index, logic [CFG_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= index;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (index == CFG_HALF_WIDTH) model_half_width = value;
        else model_half_height = value;
    endtask

    // Returns once every queued segment has been sent and every predicted
    // pixel has come back, so the block is idle.
    task automatic wait_drained();
        do @(negedge aclk);
        while (segments_pending.size() != 0 || s_tvalid || pixels_due.size() != 0);
    endtask

    initial begin
        logic [CFG_W-1:0] width_plan[6];
        logic [CFG_W-1:0] height_plan[6];
        segment_t seg;

        // Register settings per phase: out-of-range zero and 63, the smallest,
        // the nominal size, a random pick and an uneven pair.
        width_plan  = '{6'd0,  6'd63, 6'd1, 6'd32, 6'd0, 6'd5};
        height_plan = '{6'd63, 6'd0,  6'd1, 6'd32, 6'd0, 6'd17};
        width_plan[4] = CFG_W'($urandom_range(0, 63));
        height_plan[4] = CFG_W'($urandom_range(0, 63));

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed segments under the reset sizes of 32 by 32.
        // A point at the origin and a point on the most negative corner.
        segments_pending.push_back(make_segment(0, 0, 0, 0, 32'h0000_0000));
        segments_pending.push_back(make_segment(-524288, -524288, -524288, -524288,
                                                32'hFFFF_FFFF));
        // Corner to corner in both directions: the step count clamps.
        segments_pending.push_back(make_segment(524287, 524287, -524288, -524288,
                                                32'hA5A5_5A5A));
        segments_pending.push_back(make_segment(-524288, -524288, 524287, 524287,
                                                32'h5A5A_A5A5));
        segments_pending.push_back(make_segment(-524288, 524287, 524287, -524288,
                                                32'h0000_0001));
        // Horizontal and vertical, each way, and both diagonals.
        segments_pending.push_back(make_segment(0, 0, 10 * 256, 0, 32'h1111_1111));
        segments_pending.push_back(make_segment(0, 0, -10 * 256, 0, 32'h2222_2222));
        segments_pending.push_back(make_segment(0, 0, 0, 7 * 256, 32'h3333_3333));
        segments_pending.push_back(make_segment(0, 0, 0, -7 * 256, 32'h4444_4444));
        segments_pending.push_back(make_segment(0, 0, 6 * 256, 6 * 256, 32'h5555_5555));
        segments_pending.push_back(make_segment(0, 0, -6 * 256, 6 * 256, 32'h6666_6666));
        // Equal deltas are a tie and take the height limit; one fraction more
        // in x makes it x-major.
        segments_pending.push_back(make_segment(0, 0, 40 * 256, -40 * 256, 32'h7777_7777));
        segments_pending.push_back(make_segment(0, 0, 40 * 256 + 1, -40 * 256,
                                                32'h8888_8888));
        // Major delta exactly at the half size steps the full amount; one
        // fraction beyond clamps to one step less.
        segments_pending.push_back(make_segment(100, 200, 100 + 32 * 256, 200, 32'h9999_9999));
        segments_pending.push_back(make_segment(100, 200, 101 + 32 * 256, 200, 32'hAAAA_AAAA));
        segments_pending.push_back(make_segment(-5, 7, -5, 7 + 32 * 256 + 1, 32'hBBBB_BBBB));
        // Under one pixel of travel: a single pixel with a nonzero increment.
        segments_pending.push_back(make_segment(300, -300, 300 + 255, -300 - 100,
                                                32'hCCCC_CCCC));
        // Negative fractional positions truncate toward zero as they cross it.
        segments_pending.push_back(make_segment(-384, -640, 3 * 256 + 128, 640,
                                                32'hDDDD_DDDD));
        segments_pending.push_back(make_segment(-1 * 256 - 1, 2 * 256 + 3, 5 * 256 + 77,
                                                -2 * 256 - 3, 32'hEEEE_EEEE));
        // Shallow slope near the top of the positive range.
        segments_pending.push_back(make_segment(524287 - 20 * 256, 524287,
                                                524287, 524287 - 3 * 256, 32'h0F0F_F0F0));
        wait_drained();

        // Random phases, each under its own pair of sizes. Now and then a
        // segment holds the sender until the block has emptied out.
        for (int phase = 0; phase < 6; phase++) begin
            write_half(CFG_HALF_WIDTH, width_plan[phase]);
            write_half(CFG_HALF_HEIGHT, height_plan[phase]);
            for (int n = 0; n < 18; n++) begin
                seg = random_segment();
                seg.hold_until_empty = (n == 9) || ($urandom_range(0, 11) == 0);
                segments_pending.push_back(seg);
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pixels_due.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
rtl/dda_pkg.sv
rtl/dda_div.sv
rtl/dda_line_rasterizer.sv
verif/dda_line_rasterizer_test.sv
